// File: rtl/core/aaq_pkg.sv
// ----------------------------------------------------------------------------
// aaq_pkg
// Shared types, constants and helpers for the axis-angle to quaternion unit.
// ----------------------------------------------------------------------------
package aaq_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int RECIP_BITS   = 47;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
    localparam logic [32:0]        RECIP_INIT  = 33'd32768;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_req;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic               axis_zero;
    } t_rsp;

    typedef struct packed {
        t_req req;
        logic zero;
    } t_side;

    typedef struct packed {
        logic signed [32:0] u_x;
        logic signed [32:0] u_y;
        logic signed [32:0] u_z;
        logic               zero;
    } t_cside;

    function automatic logic [31:0] f_atan(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h3243F6A8;
            1:       v = 32'h1DAC6705;
            2:       v = 32'h0FADBAFC;
            3:       v = 32'h07F56EA6;
            4:       v = 32'h03FEAB76;
            5:       v = 32'h01FFD55B;
            6:       v = 32'h00FFFAAA;
            7:       v = 32'h007FFF55;
            8:       v = 32'h003FFFEA;
            9:       v = 32'h001FFFFD;
            10:      v = 32'h000FFFFF;
            11:      v = 32'h0007FFFF;
            12:      v = 32'h0003FFFF;
            13:      v = 32'h0001FFFF;
            14:      v = 32'h0000FFFF;
            15:      v = 32'h00007FFF;
            16:      v = 32'h00003FFF;
            17:      v = 32'h00001FFF;
            18:      v = 32'h00000FFF;
            19:      v = 32'h000007FF;
            20:      v = 32'h000003FF;
            21:      v = 32'h000001FF;
            22:      v = 32'h000000FF;
            23:      v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] f_sat(input logic signed [20:0] v);
        logic signed [15:0] r;
        if (v > 21'sd16384) begin
            r = ONE_Q14;
        end else if (v < -21'sd16384) begin
            r = -ONE_Q14;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/aaq_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// aaq_sqrt_pipe
// Digit-by-digit square root of d * 2^32, one result bit per stage.
// ----------------------------------------------------------------------------
module aaq_sqrt_pipe
    import aaq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_d,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [31:0] o_root,
    output t_side       o_side
);

    logic        r_v    [SQRT_STEPS];
    logic [31:0] r_d    [SQRT_STEPS];
    logic [31:0] r_root [SQRT_STEPS];
    logic [35:0] r_rem  [SQRT_STEPS];
    t_side       r_side [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_stage
        localparam int I = SQRT_STEPS - 1 - j;
        logic        s_v;
        logic [31:0] s_d;
        logic [31:0] s_root;
        logic [35:0] s_rem;
        t_side       s_side;
        logic [1:0]  pair;
        logic [35:0] t;
        logic [35:0] trial;
        logic [31:0] n_root;
        logic [35:0] n_rem;

        if (j == 0) begin : g_src0
            assign s_v    = i_valid;
            assign s_d    = i_d;
            assign s_root = '0;
            assign s_rem  = '0;
            assign s_side = i_side;
        end else begin : g_srcn
            assign s_v    = r_v[j-1];
            assign s_d    = r_d[j-1];
            assign s_root = r_root[j-1];
            assign s_rem  = r_rem[j-1];
            assign s_side = r_side[j-1];
        end

        if (I >= 16) begin : g_pair
            assign pair = s_d[2*I-31 -: 2];
        end else begin : g_nopair
            assign pair = 2'b00;
        end

        always_comb begin
            t     = {s_rem[33:0], pair};
            trial = {2'b00, s_root, 2'b01};
            if (t >= trial) begin
                n_rem  = t - trial;
                n_root = {s_root[30:0], 1'b1};
            end else begin
                n_rem  = t;
                n_root = {s_root[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[j]    <= s_d;
                r_root[j] <= n_root;
                r_rem[j]  <= n_rem;
                r_side[j] <= s_side;
            end
        end
    end

    assign o_valid = r_v[SQRT_STEPS-1];
    assign o_root  = r_root[SQRT_STEPS-1];
    assign o_side  = r_side[SQRT_STEPS-1];

endmodule

// File: rtl/core/aaq_recip_pipe.sv
// ----------------------------------------------------------------------------
// aaq_recip_pipe
// Restoring divide 2^62 / s, one quotient bit per stage.
// ----------------------------------------------------------------------------
module aaq_recip_pipe
    import aaq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [31:0]           i_s,
    input  t_side                 i_side,
    output logic                  o_valid,
    output logic [RECIP_BITS-1:0] o_recip,
    output t_side                 o_side
);

    logic                  r_v    [RECIP_BITS];
    logic [31:0]           r_s    [RECIP_BITS];
    logic [32:0]           r_rem  [RECIP_BITS];
    logic [RECIP_BITS-1:0] r_q    [RECIP_BITS];
    t_side                 r_side [RECIP_BITS];

    for (genvar k = 0; k < RECIP_BITS; k++) begin : g_stage
        logic                  s_v;
        logic [31:0]           s_s;
        logic [32:0]           s_rem;
        logic [RECIP_BITS-1:0] s_q;
        t_side                 s_side;
        logic [33:0]           t;
        logic [33:0]           dv;
        logic [33:0]           diff;
        logic [32:0]           n_rem;
        logic [RECIP_BITS-1:0] n_q;

        if (k == 0) begin : g_src0
            assign s_v    = i_valid;
            assign s_s    = i_s;
            assign s_rem  = RECIP_INIT;
            assign s_q    = '0;
            assign s_side = i_side;
        end else begin : g_srcn
            assign s_v    = r_v[k-1];
            assign s_s    = r_s[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_q    = r_q[k-1];
            assign s_side = r_side[k-1];
        end

        always_comb begin
            t    = {s_rem, 1'b0};
            dv   = {2'b00, s_s};
            diff = t - dv;
            if (t >= dv) begin
                n_rem = diff[32:0];
                n_q   = {s_q[RECIP_BITS-2:0], 1'b1};
            end else begin
                n_rem = t[32:0];
                n_q   = {s_q[RECIP_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k]    <= s_s;
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
                r_side[k] <= s_side;
            end
        end
    end

    assign o_valid = r_v[RECIP_BITS-1];
    assign o_recip = r_q[RECIP_BITS-1];
    assign o_side  = r_side[RECIP_BITS-1];

endmodule

// File: rtl/core/aaq_cordic_pipe.sv
// ----------------------------------------------------------------------------
// aaq_cordic_pipe
// Half-angle quadrant reduction, then one CORDIC rotation per stage.
// ----------------------------------------------------------------------------
module aaq_cordic_pipe
    import aaq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [15:0] i_angle,
    input  t_cside             i_side,
    output logic               o_valid,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin,
    output t_cside             o_side
);

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               neg;
        t_cside             side;
    } t_cst;

    logic r_v [CORDIC_N+1];
    t_cst r_st [CORDIC_N+1];
    t_cst n_red;

    always_comb begin
        logic signed [33:0] theta;
        theta        = {i_angle[15], i_angle, 17'd0};
        n_red.x      = GAIN_Q30;
        n_red.y      = '0;
        n_red.side   = i_side;
        n_red.neg    = 1'b0;
        n_red.z      = theta;
        if (theta > HALF_PI_Q30) begin
            n_red.z   = theta - PI_Q30;
            n_red.neg = 1'b1;
        end else if (theta < -HALF_PI_Q30) begin
            n_red.z   = theta + PI_Q30;
            n_red.neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_red;
        end
    end

    for (genvar k = 1; k <= CORDIC_N; k++) begin : g_stage
        localparam int I = k - 1;
        localparam logic signed [33:0] ATAN = {2'b00, f_atan(I)};
        t_cst n_st;

        always_comb begin
            n_st = r_st[k-1];
            if (!r_st[k-1].z[33]) begin
                n_st.x = r_st[k-1].x - (r_st[k-1].y >>> I);
                n_st.y = r_st[k-1].y + (r_st[k-1].x >>> I);
                n_st.z = r_st[k-1].z - ATAN;
            end else begin
                n_st.x = r_st[k-1].x + (r_st[k-1].y >>> I);
                n_st.y = r_st[k-1].y - (r_st[k-1].x >>> I);
                n_st.z = r_st[k-1].z + ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_valid = r_v[CORDIC_N];
    assign o_cos   = r_st[CORDIC_N].neg ? -r_st[CORDIC_N].x : r_st[CORDIC_N].x;
    assign o_sin   = r_st[CORDIC_N].neg ? -r_st[CORDIC_N].y : r_st[CORDIC_N].y;
    assign o_side  = r_st[CORDIC_N].side;

endmodule

// File: rtl/core/axis_angle_to_quaternion_unit.sv
// ----------------------------------------------------------------------------
// axis_angle_to_quaternion_unit
// Turns a Q4.12 angle and a Q2.14 axis into a saturated Q2.14 unit quaternion.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per cycle while the skid is empty. The depth
// is set by the 32-stage square root and the 47-stage reciprocal of the axis
// length; the CORDIC for the half angle runs after them. A two-entry output
// (last stage plus skid) lets a request enter while a finished one waits. A
// zero axis returns the identity quaternion with axis_zero set.
module axis_angle_to_quaternion_unit
    import aaq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    logic en;

    // squares
    logic        r_s1_v;
    t_req        r_s1_req;
    logic [30:0] r_sq_x, r_sq_y, r_sq_z;
    logic signed [31:0] n_sq_x, n_sq_y, n_sq_z;

    // sum
    logic        r_s2_v;
    logic [31:0] r_d;
    t_side       r_s2_side;
    logic [31:0] n_d;

    logic        sq_v;
    logic [31:0] sq_root;
    t_side       sq_side;

    logic                  rc_v;
    logic [RECIP_BITS-1:0] rc_r;
    t_side                 rc_side;

    // axis scaling
    logic               r_m1_v;
    t_side              r_m1_side;
    logic signed [39:0] r_ph_x, r_ph_y, r_ph_z;
    logic signed [40:0] r_pl_x, r_pl_y, r_pl_z;
    logic signed [24:0] rhi;
    logic signed [24:0] rlo;

    logic               r_m2_v;
    logic signed [15:0] r_m2_angle;
    t_cside             r_m2_side;
    t_cside             n_m2_side;

    logic               cd_v;
    logic signed [33:0] cd_cos;
    logic signed [33:0] cd_sin;
    t_cside             cd_side;

    // output products
    logic               r_f1_v;
    logic               r_f1_zero;
    logic signed [66:0] r_pr_x, r_pr_y, r_pr_z;
    logic signed [33:0] r_cw;

    logic r_f2_v;
    t_rsp r_f2_data;
    t_rsp n_f2_data;

    logic r_skid_v;
    t_rsp r_skid_data;

    assign en         = ~r_skid_v;
    assign o_in_ready = en;

    always_comb begin
        n_sq_x = i_in_data.axis_x * i_in_data.axis_x;
        n_sq_y = i_in_data.axis_y * i_in_data.axis_y;
        n_sq_z = i_in_data.axis_z * i_in_data.axis_z;
        n_d    = {1'b0, r_sq_x} + {1'b0, r_sq_y} + {1'b0, r_sq_z};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_in_valid & o_in_ready;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_req       <= i_in_data;
            r_sq_x         <= n_sq_x[30:0];
            r_sq_y         <= n_sq_y[30:0];
            r_sq_z         <= n_sq_z[30:0];
            r_d            <= n_d;
            r_s2_side.req  <= r_s1_req;
            r_s2_side.zero <= (n_d == 32'd0);
        end
    end

    aaq_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_v),
        .i_d     (r_d),
        .i_side  (r_s2_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    aaq_recip_pipe u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_s     (sq_root),
        .i_side  (sq_side),
        .o_valid (rc_v),
        .o_recip (rc_r),
        .o_side  (rc_side)
    );

    assign rhi = {2'b00, rc_r[RECIP_BITS-1:24]};
    assign rlo = {1'b0, rc_r[23:0]};

    always_comb begin
        logic signed [63:0] sx, sy, sz;
        sx = (64'(r_ph_x) <<< 24) + 64'(r_pl_x);
        sy = (64'(r_ph_y) <<< 24) + 64'(r_pl_y);
        sz = (64'(r_ph_z) <<< 24) + 64'(r_pl_z);
        n_m2_side.u_x  = sx[48:16];
        n_m2_side.u_y  = sy[48:16];
        n_m2_side.u_z  = sz[48:16];
        n_m2_side.zero = r_m1_side.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= rc_v;
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_side  <= rc_side;
            r_ph_x     <= 40'(rc_side.req.axis_x * rhi);
            r_ph_y     <= 40'(rc_side.req.axis_y * rhi);
            r_ph_z     <= 40'(rc_side.req.axis_z * rhi);
            r_pl_x     <= 41'(rc_side.req.axis_x * rlo);
            r_pl_y     <= 41'(rc_side.req.axis_y * rlo);
            r_pl_z     <= 41'(rc_side.req.axis_z * rlo);
            r_m2_angle <= r_m1_side.req.angle;
            r_m2_side  <= n_m2_side;
        end
    end

    aaq_cordic_pipe u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m2_v),
        .i_angle (r_m2_angle),
        .i_side  (r_m2_side),
        .o_valid (cd_v),
        .o_cos   (cd_cos),
        .o_sin   (cd_sin),
        .o_side  (cd_side)
    );

    always_comb begin
        logic signed [66:0] tx, ty, tz;
        logic signed [33:0] tw;
        tx = r_pr_x + (67'sd1 <<< 45);
        ty = r_pr_y + (67'sd1 <<< 45);
        tz = r_pr_z + (67'sd1 <<< 45);
        tw = r_cw + 34'sd32768;
        if (r_f1_zero) begin
            n_f2_data.quat_x = '0;
            n_f2_data.quat_y = '0;
            n_f2_data.quat_z = '0;
            n_f2_data.quat_w = ONE_Q14;
        end else begin
            n_f2_data.quat_x = f_sat(tx[66:46]);
            n_f2_data.quat_y = f_sat(ty[66:46]);
            n_f2_data.quat_z = f_sat(tz[66:46]);
            n_f2_data.quat_w = f_sat({{3{tw[33]}}, tw[33:16]});
        end
        n_f2_data.axis_zero = r_f1_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= cd_v;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_zero <= cd_side.zero;
            r_pr_x    <= 67'(cd_sin) * 67'(cd_side.u_x);
            r_pr_y    <= 67'(cd_sin) * 67'(cd_side.u_y);
            r_pr_z    <= 67'(cd_sin) * 67'(cd_side.u_z);
            r_cw      <= cd_cos;
            r_f2_data <= n_f2_data;
        end
    end

    // skid: catches the last stage when the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            r_skid_v <= ~i_out_ready;
        end else begin
            r_skid_v <= r_f2_v & ~i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid_data <= r_f2_data;
        end
    end

    assign o_out_valid = r_skid_v | r_f2_v;
    assign o_out_data  = r_skid_v ? r_skid_data : r_f2_data;

    a_zero_identity : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.axis_zero |->
            o_out_data.quat_w == ONE_Q14 && o_out_data.quat_x == 16'sd0 &&
            o_out_data.quat_y == 16'sd0 && o_out_data.quat_z == 16'sd0)
        else $error("zero axis without identity quaternion");

    a_w_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.quat_w <= ONE_Q14 && o_out_data.quat_w >= -ONE_Q14)
        else $error("quat_w out of range");

    a_skid_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !i_out_ready |=> r_skid_v && $stable(r_skid_data))
        else $error("skid entry lost while stalled");

    a_skid_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_f2_v))
        else $error("skid loaded from empty stage");

endmodule
